/* rtl/core/irn_pkg.sv */
// shared types, constants and symbol tables for the roman numeral unit
package irn_pkg;

  localparam int NUM_W   = 12;
  localparam int CHAR_W  = 7;
  localparam int ADDR_W  = 4;
  localparam int DIGIT_W = 4;
  localparam int PLACES  = 4;
  localparam int PLACE_W = 2;
  localparam int LEN_W   = 3;
  localparam int SUB_W   = 2;

  localparam logic [NUM_W-1:0] MAX_VALUE = 12'd3999;

  // floor(x * 6554 / 2^16) equals floor(x / 10) for every 12-bit x
  localparam int               RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_TEN = 13'd6554;
  localparam int               RECIP_SHIFT = 16;
  localparam int               PROD_W      = NUM_W + RECIP_W;
  localparam int               QUOT_W      = PROD_W - RECIP_SHIFT;

  localparam logic [CHAR_W-1:0] CH_NONE = 7'h00;
  localparam logic [CHAR_W-1:0] CH_M    = 7'h4D;
  localparam logic [CHAR_W-1:0] CH_D    = 7'h44;
  localparam logic [CHAR_W-1:0] CH_C    = 7'h43;
  localparam logic [CHAR_W-1:0] CH_L    = 7'h4C;
  localparam logic [CHAR_W-1:0] CH_X    = 7'h58;
  localparam logic [CHAR_W-1:0] CH_V    = 7'h56;
  localparam logic [CHAR_W-1:0] CH_I    = 7'h49;

  localparam logic [PLACE_W-1:0] PL_UNITS     = 2'd0;
  localparam logic [PLACE_W-1:0] PL_TENS      = 2'd1;
  localparam logic [PLACE_W-1:0] PL_HUNDREDS  = 2'd2;
  localparam logic [PLACE_W-1:0] PL_THOUSANDS = 2'd3;

  // microprogram addresses
  localparam logic [ADDR_W-1:0] A_WAIT  = 4'd0;
  localparam logic [ADDR_W-1:0] A_CHECK = 4'd1;
  localparam logic [ADDR_W-1:0] A_DIV0  = 4'd2;
  localparam logic [ADDR_W-1:0] A_DIV1  = 4'd3;
  localparam logic [ADDR_W-1:0] A_DIV2  = 4'd4;
  localparam logic [ADDR_W-1:0] A_EMIT3 = 4'd5;
  localparam logic [ADDR_W-1:0] A_EMIT2 = 4'd6;
  localparam logic [ADDR_W-1:0] A_EMIT1 = 4'd7;
  localparam logic [ADDR_W-1:0] A_EMIT0 = 4'd8;
  localparam logic [ADDR_W-1:0] A_ERR   = 4'd9;

  typedef enum logic [2:0] {
    K_WAIT,
    K_CHECK,
    K_DIV,
    K_EMIT,
    K_ERR
  } kind_t;

  typedef enum logic [1:0] {
    SYM_ONE,
    SYM_FIVE,
    SYM_TEN
  } sym_t;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef struct packed {
    kind_t               kind;
    logic [PLACE_W-1:0]  place;
    logic [ADDR_W-1:0]   target;
  } uword_t;

  typedef struct packed {
    logic               load;
    logic               div;
    logic [PLACE_W-1:0] place;
  } dp_ctrl_t;

  typedef struct packed {
    logic                oor;
    digit_t [PLACES-1:0] digits;
  } dp_stat_t;

  function automatic logic [LEN_W-1:0] digit_len(input digit_t d);
    logic [LEN_W-1:0] n;
    unique case (d)
      4'd1, 4'd5:        n = 3'd1;
      4'd2, 4'd4, 4'd6,
      4'd9:              n = 3'd2;
      4'd3, 4'd7:        n = 3'd3;
      4'd8:              n = 3'd4;
      default:           n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic sym_t sym_at(input digit_t d, input logic [SUB_W-1:0] idx);
    sym_t s;
    if (d == 4'd4) begin
      s = (idx == '0) ? SYM_ONE : SYM_FIVE;
    end else if (d == 4'd9) begin
      s = (idx == '0) ? SYM_ONE : SYM_TEN;
    end else if (d >= 4'd5) begin
      s = (idx == '0) ? SYM_FIVE : SYM_ONE;
    end else begin
      s = SYM_ONE;
    end
    return s;
  endfunction

  function automatic logic [CHAR_W-1:0] symbol_char(input logic [PLACE_W-1:0] place,
                                                    input sym_t s);
    logic [CHAR_W-1:0] c;
    unique case (place)
      PL_THOUSANDS: c = CH_M;
      PL_HUNDREDS:  c = (s == SYM_FIVE) ? CH_D : ((s == SYM_TEN) ? CH_M : CH_C);
      PL_TENS:      c = (s == SYM_FIVE) ? CH_L : ((s == SYM_TEN) ? CH_C : CH_X);
      default:      c = (s == SYM_FIVE) ? CH_V : ((s == SYM_TEN) ? CH_X : CH_I);
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/irn_rom.sv */
// microprogram store: one control word per step address
module irn_rom (
  input  logic [irn_pkg::ADDR_W-1:0] addr,
  output irn_pkg::uword_t            uword
);
  import irn_pkg::*;

  always_comb begin
    unique case (addr)
      A_WAIT:  uword = '{kind: K_WAIT,  place: PL_UNITS,     target: A_CHECK};
      A_CHECK: uword = '{kind: K_CHECK, place: PL_UNITS,     target: A_DIV0};
      A_DIV0:  uword = '{kind: K_DIV,   place: PL_UNITS,     target: A_DIV1};
      A_DIV1:  uword = '{kind: K_DIV,   place: PL_TENS,      target: A_DIV2};
      A_DIV2:  uword = '{kind: K_DIV,   place: PL_HUNDREDS,  target: A_EMIT3};
      A_EMIT3: uword = '{kind: K_EMIT,  place: PL_THOUSANDS, target: A_EMIT2};
      A_EMIT2: uword = '{kind: K_EMIT,  place: PL_HUNDREDS,  target: A_EMIT1};
      A_EMIT1: uword = '{kind: K_EMIT,  place: PL_TENS,      target: A_EMIT0};
      A_EMIT0: uword = '{kind: K_EMIT,  place: PL_UNITS,     target: A_WAIT};
      A_ERR:   uword = '{kind: K_ERR,   place: PL_UNITS,     target: A_WAIT};
      default: uword = '{kind: K_WAIT,  place: PL_UNITS,     target: A_WAIT};
    endcase
  end

endmodule

/* rtl/core/irn_datapath.sv */
// working value, range check and shared divide-by-ten step for digit extraction
module irn_datapath (
  input  logic                      clk,
  input  irn_pkg::dp_ctrl_t         ctrl,
  input  logic [irn_pkg::NUM_W-1:0] number,
  output irn_pkg::dp_stat_t         stat
);
  import irn_pkg::*;

  logic [NUM_W-1:0]    work;
  digit_t [PLACES-1:0] digits;
  logic [PROD_W-1:0]   prod;
  logic [QUOT_W-1:0]   quot;
  logic [NUM_W-1:0]    quot_ten;
  logic [NUM_W-1:0]    rem_full;

  assign prod     = PROD_W'(work) * PROD_W'(RECIP_TEN);
  assign quot     = prod[PROD_W-1:RECIP_SHIFT];
  // times ten by shift and add
  assign quot_ten = NUM_W'({quot, 3'b000}) + NUM_W'({quot, 1'b0});
  assign rem_full = work - quot_ten;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      work <= number;
    end else if (ctrl.div) begin
      work                <= NUM_W'(quot);
      digits[ctrl.place]  <= rem_full[DIGIT_W-1:0];
      if (ctrl.place == PL_HUNDREDS) begin
        digits[PL_THOUSANDS] <= quot[DIGIT_W-1:0];
      end
    end
  end

  assign stat.oor    = (work == '0) || (work > MAX_VALUE);
  assign stat.digits = digits;

endmodule

/* rtl/core/integer_to_roman_numeral_unit.sv */
// top level: microcoded sequencer that emits the roman numeral of each request
//
// One request at a time. After the request is taken, a check step tests the
// range and three steps split the value into decimal digits through a
// single divide-by-ten step. The four places then emit one character per
// cycle while the output register has room; a place with no symbols still
// passes through its own emit step. An out-of-range number goes from the
// check step to an error step and gives one character 0 with last and
// out_of_range set. A full output register stalls the sequencer.
module integer_to_roman_numeral_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [irn_pkg::NUM_W-1:0]  number,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [irn_pkg::CHAR_W-1:0] character,
  output logic                       last,
  output logic                       out_of_range
);
  import irn_pkg::*;

  logic [ADDR_W-1:0] addr, addr_next;
  logic [SUB_W-1:0]  sub, sub_next;
  uword_t            uw;
  dp_ctrl_t          ctrl;
  dp_stat_t          stat;
  digit_t            cur_digit;
  logic [LEN_W-1:0]  len;
  logic              tail_empty;
  logic              slot_free;
  logic              sub_final;
  logic              emit;
  logic [CHAR_W-1:0] emit_char;
  logic              emit_last;
  logic              emit_oor;

  irn_rom u_rom (
    .addr  (addr),
    .uword (uw)
  );

  irn_datapath u_dp (
    .clk    (clk),
    .ctrl   (ctrl),
    .number (number),
    .stat   (stat)
  );

  assign cur_digit = stat.digits[uw.place];
  assign len       = digit_len(cur_digit);
  assign slot_free = !out_valid || out_ready;
  assign sub_final = ({1'b0, sub} == (len - 3'd1));
  assign in_ready  = (uw.kind == K_WAIT);

  // no lower place will produce a symbol
  always_comb begin
    tail_empty = 1'b1;
    for (int i = 0; i < PLACES; i++) begin
      if ((PLACE_W'(i) < uw.place) && (stat.digits[i] != '0)) begin
        tail_empty = 1'b0;
      end
    end
  end

  always_comb begin
    addr_next = addr;
    sub_next  = sub;
    ctrl      = '0;
    emit      = 1'b0;
    emit_char = CH_NONE;
    emit_last = 1'b0;
    emit_oor  = 1'b0;
    unique case (uw.kind)
      K_WAIT: begin
        if (in_valid) begin
          ctrl.load = 1'b1;
          addr_next = uw.target;
        end
      end
      K_CHECK: begin
        sub_next  = '0;
        addr_next = stat.oor ? A_ERR : uw.target;
      end
      K_DIV: begin
        ctrl.div   = 1'b1;
        ctrl.place = uw.place;
        addr_next  = uw.target;
      end
      K_EMIT: begin
        if (len == '0) begin
          addr_next = uw.target;
        end else if (slot_free) begin
          emit      = 1'b1;
          emit_char = symbol_char(uw.place, sym_at(cur_digit, sub));
          emit_last = sub_final && tail_empty;
          if (sub_final) begin
            sub_next  = '0;
            addr_next = uw.target;
          end else begin
            sub_next = sub + 2'd1;
          end
        end
      end
      K_ERR: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          emit_oor  = 1'b1;
          addr_next = uw.target;
        end
      end
      default: begin
        addr_next = A_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr      <= A_WAIT;
      sub       <= '0;
      out_valid <= 1'b0;
    end else begin
      addr <= addr_next;
      sub  <= sub_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      character    <= emit_char;
      last         <= emit_last;
      out_of_range <= emit_oor;
    end
  end

endmodule
